>>> sv/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack machine package
// Shared widths, instruction codes and status codes.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOD   = 4'd5,
    OP_NEG   = 4'd6,
    OP_DROP  = 4'd7,
    OP_SWAP  = 4'd8,
    OP_COPY  = 4'd9,
    OP_WRITE = 4'd10,
    OP_NL    = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_FULL  = 3'd3,
    ST_DIVZ  = 3'd4,
    ST_INDEX = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0]       req_type;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               emit_valid;
    logic signed [31:0] emit_value;
    logic               newline_out;
  } rsp_t;

endpackage

>>> sv/rpn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN channel interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface rpn_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/rpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> sv/rpn_stack_machine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack machine top level
// Executes one reverse-Polish instruction per transfer on a RAM stack.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. The stack lives in a single-port
// RAM with registered read data, and the top entry is read already in the
// cycle an instruction is taken. Newline, unknown codes and any instruction
// under a sticky error go straight to S_OUT. Push, drop and write are the next
// quickest, then neg, then copy, then add, sub and swap, and mul is slowest
// but for div and mod, which use the radix-2 divider that retires one quotient
// bit per cycle. An error that is found early ends the instruction sooner. The
// next instruction can be taken in the cycle the response is taken, so div and
// mod are the slowest items. A finished result waits in an output register,
// and no request is taken while it waits. Errors are sticky until reset.
module rpn_stack_machine_top (
  input  logic clk_i,
  input  logic rst_ni,
  rpn_if.sink   req_i,
  rpn_if.source rsp_o
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TOP, S_SEC, S_EXEC, S_MULW, S_DIV, S_DIVF, S_WR,
    S_IDX, S_CPY, S_SWA, S_SWB, S_SWC, S_OUT
  } state_e;

  state_e              state_q;
  logic [3:0]          op_q;
  logic signed [31:0]  arg_q;
  logic [CountW-1:0]   cnt_q;
  status_e             err_q;
  logic signed [31:0]  top_q, sec_q, res_q;
  logic signed [63:0]  prod_q;
  rsp_t                rsp_q;
  logic                rsp_valid_q;

  // Divider registers.
  logic [4:0]          dcnt_q;
  logic [31:0]         quo_q, rem_q, dvs_q;
  logic                nneg_q, dneg_q;

  logic                we;
  logic [AddrW-1:0]    addr;
  logic [DataW-1:0]    wdata, rdata;
  logic [AddrW-1:0]    swap_addr_q;

  rpn_ram #(.Width(DataW), .Depth(StackDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  logic [CountW-1:0] cnt_m1, cnt_m2;
  assign cnt_m1 = cnt_q - CountW'(1);
  assign cnt_m2 = cnt_q - CountW'(2);

  // Index check for swap and copy.
  logic idx_bad;
  assign idx_bad = arg_q[31] || ({1'b0, arg_q} >= {{(33 - CountW){1'b0}}, cnt_q});
  logic [CountW-1:0] idx_addr;
  assign idx_addr = cnt_m1 - arg_q[CountW-1:0];

  assign req_i.ready = (state_q == S_IDLE) && !(rsp_valid_q && !rsp_o.ready);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Sum and difference with one guard bit for the overflow check.
  logic [32:0] sum_w, dif_w;
  assign sum_w = {sec_q[31], sec_q} + {top_q[31], top_q};
  assign dif_w = {sec_q[31], sec_q} - {top_q[31], top_q};

  // Divider step: restoring, one bit per cycle.
  logic [32:0] dtrial;
  assign dtrial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  // Euclidean fix of truncated result.
  logic [31:0] tr;
  logic [32:0] qmag, eq, er;
  always_comb begin
    qmag = {1'b0, quo_q};
    eq   = (nneg_q ^ dneg_q) ? -qmag : qmag;
    tr   = nneg_q ? -rem_q : rem_q;
    er   = {tr[31], tr};
    if (tr != 32'd0 && nneg_q) begin
      if (!dneg_q) begin
        er = er + {top_q[31], top_q};
        eq = eq - 33'd1;
      end else begin
        er = er - {top_q[31], top_q};
        eq = eq + 33'd1;
      end
    end
  end

  // Memory port control. In idle the top entry is read so that it is
  // ready in the first cycle of the instruction.
  always_comb begin
    we    = 1'b0;
    addr  = cnt_m1[AddrW-1:0];
    wdata = res_q;
    unique case (state_q)
      S_TOP:  addr = cnt_m2[AddrW-1:0];
      S_IDX:  addr = idx_addr[AddrW-1:0];
      S_WR: begin
        we   = 1'b1;
        addr = cnt_q[AddrW-1:0];
      end
      S_SWB: begin
        we    = 1'b1;
        wdata = sec_q;
      end
      S_SWC: begin
        we    = 1'b1;
        addr  = swap_addr_q;
        wdata = top_q;
      end
      default: ;
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PUSH;
      arg_q       <= '0;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      top_q       <= '0;
      sec_q       <= '0;
      res_q       <= '0;
      prod_q      <= '0;
      dcnt_q      <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      nneg_q      <= 1'b0;
      dneg_q      <= 1'b0;
      swap_addr_q <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // The response register is empty whenever the sequencer reaches S_OUT.
      if (state_q == S_OUT) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            op_q  <= req_i.data.req_type;
            arg_q <= req_i.data.operand;
            rsp_q.status      <= ST_OK;
            rsp_q.emit_valid  <= 1'b0;
            rsp_q.emit_value  <= '0;
            rsp_q.newline_out <= (err_q == ST_OK) && (req_i.data.req_type == OP_NL);
            if (err_q != ST_OK) begin
              state_q <= S_OUT;
            end else begin
              unique case (req_i.data.req_type)
                OP_PUSH: begin
                  res_q <= req_i.data.operand;
                  if (cnt_q == CountW'(StackDepth)) begin
                    err_q   <= ST_FULL;
                    state_q <= S_OUT;
                  end else state_q <= S_WR;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                OP_NEG, OP_DROP, OP_WRITE: begin
                  if (cnt_q == '0) begin
                    err_q   <= ST_UNDER;
                    state_q <= S_OUT;
                  end else state_q <= S_TOP;
                end
                // Swap with depth zero does nothing, even on an empty stack.
                OP_SWAP: state_q <= (req_i.data.operand == '0) ? S_OUT : S_IDX;
                OP_COPY: state_q <= S_IDX;
                default: state_q <= S_OUT;
              endcase
            end
          end
        end
        S_TOP: begin
          // Top arrives and is popped; the second read is issued.
          top_q <= rdata;
          cnt_q <= cnt_m1;
          unique case (op_q)
            OP_NEG: begin
              if (rdata == 32'h8000_0000) begin
                err_q   <= ST_OVER;
                state_q <= S_OUT;
              end else begin
                res_q   <= -rdata;
                state_q <= S_WR;
              end
            end
            OP_DROP: state_q <= S_OUT;
            OP_WRITE: begin
              rsp_q.emit_valid <= 1'b1;
              rsp_q.emit_value <= rdata;
              state_q          <= S_OUT;
            end
            default: begin
              // A binary operator with one entry consumes it before failing.
              if (cnt_q == CountW'(1)) begin
                err_q   <= ST_UNDER;
                state_q <= S_OUT;
              end else state_q <= S_SEC;
            end
          endcase
        end
        S_SEC: begin
          sec_q   <= rdata;
          cnt_q   <= cnt_m1;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          unique case (op_q)
            OP_ADD: begin
              if (sum_w[32] != sum_w[31]) begin
                err_q   <= ST_OVER;
                state_q <= S_OUT;
              end else begin
                res_q   <= sum_w[31:0];
                state_q <= S_WR;
              end
            end
            OP_SUB: begin
              if (dif_w[32] != dif_w[31]) begin
                err_q   <= ST_OVER;
                state_q <= S_OUT;
              end else begin
                res_q   <= dif_w[31:0];
                state_q <= S_WR;
              end
            end
            OP_MUL: begin
              prod_q  <= sec_q * top_q;
              state_q <= S_MULW;
            end
            default: begin
              // Div and mod; a zero divisor leaves both operands popped.
              if (top_q == '0) begin
                err_q   <= ST_DIVZ;
                state_q <= S_OUT;
              end else begin
                nneg_q  <= sec_q[31];
                dneg_q  <= top_q[31];
                quo_q   <= sec_q[31] ? -sec_q : sec_q;
                dvs_q   <= top_q[31] ? -top_q : top_q;
                rem_q   <= '0;
                dcnt_q  <= '0;
                state_q <= S_DIV;
              end
            end
          endcase
        end
        S_MULW: begin
          if (prod_q[63:31] != {33{prod_q[31]}}) begin
            err_q   <= ST_OVER;
            state_q <= S_OUT;
          end else begin
            res_q   <= prod_q[31:0];
            state_q <= S_WR;
          end
        end
        S_DIV: begin
          if (!dtrial[32]) begin
            rem_q <= dtrial[31:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= {rem_q[30:0], quo_q[31]};
            quo_q <= {quo_q[30:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) state_q <= S_DIVF;
        end
        S_DIVF: begin
          if (op_q == OP_DIV) begin
            if (eq[32] != eq[31]) begin
              err_q   <= ST_OVER;
              state_q <= S_OUT;
            end else begin
              res_q   <= eq[31:0];
              state_q <= S_WR;
            end
          end else begin
            res_q   <= er[31:0];
            state_q <= S_WR;
          end
        end
        S_WR: begin
          cnt_q   <= cnt_q + CountW'(1);
          state_q <= S_OUT;
        end
        S_IDX: begin
          // The read of depth k is issued in this cycle.
          if (idx_bad) begin
            err_q   <= ST_INDEX;
            state_q <= S_OUT;
          end else if (op_q == OP_COPY) begin
            if (cnt_q == CountW'(StackDepth)) begin
              err_q   <= ST_FULL;
              state_q <= S_OUT;
            end else state_q <= S_CPY;
          end else begin
            swap_addr_q <= idx_addr[AddrW-1:0];
            state_q     <= S_SWA;
          end
        end
        S_CPY: begin
          res_q   <= rdata;
          state_q <= S_WR;
        end
        // Swap: keep the depth-k value, read the top, then write both back.
        S_SWA: begin
          sec_q   <= rdata;
          state_q <= S_SWB;
        end
        S_SWB: begin
          top_q   <= rdata;
          state_q <= S_SWC;
        end
        S_SWC: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          rsp_q.status <= err_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> test/tb_rpn_stack_machine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack machine testbench
// Sends directed and random instruction streams through the request channel
// while a behavioral stack calculator predicts every response. Responses are
// checked field by field in order. Both channels idle at random, and the
// response side holds off once for a long stretch so the machine backs up.
// ----------------------------------------------------------------------------
module tb_rpn_stack_machine_top;
  import rpn_pkg::*;

  localparam logic [3:0] OpUnusedFirst = 4'd12;
  localparam logic [3:0] OpUnusedLast  = 4'd15;
  localparam int unsigned RandomItems  = 420;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 60;

  logic clk;
  logic rst_n;

  rpn_if #(.T(req_t)) req_if ();
  rpn_if #(.T(rsp_t)) rsp_if ();

  rpn_stack_machine_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Calculator state used for prediction.
  logic signed [31:0] calc_mem  [StackDepth];
  logic signed [31:0] saved_mem [StackDepth];
  int unsigned        calc_cnt;
  int unsigned        saved_cnt;
  status_e            calc_err;

  req_t instr_q[$];
  rsp_t resp_q[$];

  int unsigned n_instr;
  int unsigned n_sent;
  int unsigned n_recv;
  int unsigned n_emit;
  int unsigned n_newline;
  int unsigned n_fail;
  int unsigned cycles;

  // Pops the top entry; flags underflow when the stack is empty.
  function bit calc_pop(output longint v);
    v = 0;
    if (calc_cnt == 0) begin
      calc_err = ST_UNDER;
      return 1'b0;
    end
    calc_cnt--;
    v = longint'(calc_mem[calc_cnt]);
    return 1'b1;
  endfunction

  // Pushes a value, checking signed range first and then stack space.
  function void calc_push(input longint v);
    if (v < -64'sd2147483648 || v > 64'sd2147483647) begin
      calc_err = ST_OVER;
    end else if (calc_cnt >= StackDepth) begin
      calc_err = ST_FULL;
    end else begin
      calc_mem[calc_cnt] = v[31:0];
      calc_cnt++;
    end
  endfunction

  // Executes one instruction on the calculator and forms its response.
  function void calc_step(input req_t r, output rsp_t o);
    longint top, sec, quo, rem, k, v;
    logic signed [31:0] t;
    o = '0;
    k = longint'(r.operand);
    if (calc_err == ST_OK) begin
      case (r.req_type)
        OP_PUSH: calc_push(k);
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          if (calc_pop(top) && calc_pop(sec)) begin
            case (r.req_type)
              OP_ADD: calc_push(sec + top);
              OP_SUB: calc_push(sec - top);
              OP_MUL: calc_push(sec * top);
              default: begin
                if (top == 0) begin
                  calc_err = ST_DIVZ;
                end else begin
                  // Euclidean result: the remainder is never negative.
                  quo = sec / top;
                  rem = sec % top;
                  if (rem < 0) begin
                    if (top > 0) begin
                      rem += top;
                      quo -= 1;
                    end else begin
                      rem -= top;
                      quo += 1;
                    end
                  end
                  calc_push(r.req_type == OP_DIV ? quo : rem);
                end
              end
            endcase
          end
        end
        OP_NEG: begin
          if (calc_pop(v)) calc_push(-v);
        end
        OP_DROP: begin
          void'(calc_pop(v));
        end
        OP_SWAP: begin
          if (k != 0) begin
            if (k < 0 || k >= longint'(calc_cnt)) begin
              calc_err = ST_INDEX;
            end else begin
              t = calc_mem[calc_cnt - 1];
              calc_mem[calc_cnt - 1] = calc_mem[calc_cnt - 1 - k];
              calc_mem[calc_cnt - 1 - k] = t;
            end
          end
        end
        OP_COPY: begin
          if (k < 0 || k >= longint'(calc_cnt)) calc_err = ST_INDEX;
          else calc_push(longint'(calc_mem[calc_cnt - 1 - k]));
        end
        OP_WRITE: begin
          if (calc_pop(v)) begin
            o.emit_valid = 1'b1;
            o.emit_value = v[31:0];
          end
        end
        OP_NL: o.newline_out = 1'b1;
        default: ;
      endcase
    end
    o.status = calc_err;
  endfunction

  // Queues an instruction if it keeps the machine free of errors, or
  // always when an error is wanted. Returns whether it was queued.
  function bit queue_instr(input req_t r, input bit allow_err);
    rsp_t o;
    saved_mem = calc_mem;
    saved_cnt = calc_cnt;
    calc_step(r, o);
    if (calc_err != ST_OK && !allow_err) begin
      calc_mem = saved_mem;
      calc_cnt = saved_cnt;
      calc_err = ST_OK;
      return 1'b0;
    end
    instr_q.push_back(r);
    resp_q.push_back(o);
    n_instr++;
    return 1'b1;
  endfunction

  function req_t mk(input logic [3:0] op, input logic signed [31:0] arg);
    req_t r;
    r.req_type = op;
    r.operand  = arg;
    return r;
  endfunction

  // Values: mostly small so products stay in range, some full width.
  function logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      4: return $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
      default: return $signed(32'($urandom_range(0, 200))) - 32'sd100;
    endcase
  endfunction

  function req_t rand_instr();
    int unsigned sel;
    logic [3:0] op;
    logic signed [31:0] arg;
    sel = $urandom_range(0, 99);
    arg = rand_value();
    if (calc_cnt < 3 || (calc_cnt < 180 && sel < 30)) op = OP_PUSH;
    else if (sel < 95) op = 4'($urandom_range(OP_ADD, OP_NL));
    else op = 4'($urandom_range(OpUnusedFirst, OpUnusedLast));
    if ((op == OP_SWAP || op == OP_COPY) && calc_cnt > 0 && $urandom_range(0, 4) != 0)
      arg = $urandom_range(0, calc_cnt - 1);
    return mk(op, arg);
  endfunction

  // Builds the whole instruction stream and its expected responses.
  task build_stream();
    int unsigned tries;
    int unsigned kind;
    int unsigned n_random;
    calc_cnt = 0;
    calc_err = ST_OK;

    // The closing error is chosen first; filling the stack costs items.
    kind = $urandom_range(ST_UNDER, ST_INDEX);
    n_random = (kind == ST_FULL) ? RandomItems - StackDepth : RandomItems;

    // Directed part: extremes, every instruction and the quiet cases.
    void'(queue_instr(mk(OP_SWAP, 0), 0));
    void'(queue_instr(mk(OpUnusedFirst, 32'sh7fffffff), 0));
    void'(queue_instr(mk(OpUnusedLast, 0), 0));
    void'(queue_instr(mk(OP_NL, 0), 0));
    void'(queue_instr(mk(OP_PUSH, 32'sh80000000), 0));
    void'(queue_instr(mk(OP_PUSH, 32'sh7fffffff), 0));
    void'(queue_instr(mk(OP_ADD, 0), 0));
    void'(queue_instr(mk(OP_PUSH, -32'sd1), 0));
    void'(queue_instr(mk(OP_MUL, 0), 0));
    void'(queue_instr(mk(OP_NEG, 0), 0));
    void'(queue_instr(mk(OP_PUSH, 32'sd7), 0));
    void'(queue_instr(mk(OP_PUSH, -32'sd3), 0));
    void'(queue_instr(mk(OP_DIV, 0), 0));
    void'(queue_instr(mk(OP_PUSH, -32'sd7), 0));
    void'(queue_instr(mk(OP_PUSH, 32'sd3), 0));
    void'(queue_instr(mk(OP_MOD, 0), 0));
    void'(queue_instr(mk(OP_PUSH, -32'sd7), 0));
    void'(queue_instr(mk(OP_PUSH, -32'sd3), 0));
    void'(queue_instr(mk(OP_MOD, 0), 0));
    void'(queue_instr(mk(OP_SWAP, 32'sd2), 0));
    void'(queue_instr(mk(OP_COPY, 32'sd3), 0));
    void'(queue_instr(mk(OP_SUB, 0), 0));
    void'(queue_instr(mk(OP_WRITE, 0), 0));
    void'(queue_instr(mk(OP_DROP, 0), 0));
    void'(queue_instr(mk(OP_WRITE, 0), 0));

    // Random part: error-free instruction mix with random contents.
    for (int unsigned i = 0; i < n_random; i++) begin
      tries = 0;
      while (!queue_instr(rand_instr(), 0) && tries < 50) tries++;
    end

    // Closing part: raise one kind of sticky error, then confirm it holds.
    case (kind)
      ST_UNDER: begin
        while (calc_cnt > 1) void'(queue_instr(mk(OP_DROP, 0), 0));
        if (calc_cnt == 0) void'(queue_instr(mk(OP_PUSH, rand_value()), 0));
        void'(queue_instr(mk(OP_ADD, 0), 1));
      end
      ST_OVER: begin
        void'(queue_instr(mk(OP_PUSH, 32'sh80000000), 0));
        void'(queue_instr(mk(OP_PUSH, -32'sd1), 0));
        void'(queue_instr(mk(OP_DIV, 0), 1));
      end
      ST_FULL: begin
        while (calc_cnt < StackDepth) void'(queue_instr(mk(OP_PUSH, rand_value()), 0));
        void'(queue_instr(mk(OP_PUSH, rand_value()), 1));
      end
      ST_DIVZ: begin
        void'(queue_instr(mk(OP_PUSH, rand_value()), 0));
        void'(queue_instr(mk(OP_PUSH, 0), 0));
        void'(queue_instr(mk(OP_MOD, 0), 1));
      end
      default: begin
        if ($urandom_range(0, 1) != 0) void'(queue_instr(mk(OP_COPY, calc_cnt), 1));
        else void'(queue_instr(mk(OP_SWAP, -$signed(32'($urandom_range(1, 9)))), 1));
      end
    endcase
    for (int unsigned i = 0; i < 6; i++) void'(queue_instr(rand_instr(), 1));
  endtask

  // Count request transfers at the rising edge.
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) n_sent++;
  end

  // Request driver: one instruction at a time, with random idle bursts.
  int unsigned drv_seen;
  int unsigned drv_idle;
  bit          drv_busy;
  always @(negedge clk) begin
    if (rst_n) begin
      if (drv_busy && n_sent != drv_seen) begin
        drv_busy = 1'b0;
        drv_seen = n_sent;
      end
      if (!drv_busy) begin
        if (drv_idle == 0 && n_sent < n_instr * 3 / 4 && $urandom_range(0, 9) == 0)
          drv_idle = $urandom_range(1, 9);
        if (drv_idle > 0) begin
          drv_idle--;
          req_if.valid <= 1'b0;
        end else if (instr_q.size() > 0) begin
          req_if.data  <= instr_q.pop_front();
          req_if.valid <= 1'b1;
          drv_busy = 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: random stall bursts and one long hold-off.
  int unsigned rdy_stall;
  int unsigned hold_left;
  bit          hold_done;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && n_recv >= 100) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (rdy_stall == 0 && n_sent < n_instr * 3 / 4 && $urandom_range(0, 9) == 0)
        rdy_stall = $urandom_range(1, 9);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rdy_stall > 0) begin
        rdy_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Response checker: compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      n_recv++;
      if (resp_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected response %p", $time, got);
      end else begin
        want = resp_q.pop_front();
        if (got.emit_valid) n_emit++;
        if (got.newline_out) n_newline++;
        if (got.status !== want.status || got.emit_valid !== want.emit_valid ||
            got.emit_value !== want.emit_value || got.newline_out !== want.newline_out) begin
          n_fail++;
          $display("%0t: response %0d expected %p, got %p", $time, n_recv, want, got);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d responses outstanding", $time, resp_q.size());
      $display("rpn_stack_machine_top: mismatch");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    rst_n        = 1'b0;
    build_stream();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (n_sent == n_instr && resp_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d instructions, checked %0d responses (%0d emits, %0d newlines).",
             n_instr, n_recv, n_emit, n_newline);
    $display("Final sticky status %s, %0d mismatches.", calc_err.name(), n_fail);
    if (n_fail == 0 && resp_q.size() == 0) begin
      $display("rpn_stack_machine_top: match");
    end else begin
      $display("rpn_stack_machine_top: mismatch");
    end
    $finish;
  end

endmodule
